/* rtl/core/tks_pkg.sv */
package tks_pkg;

    // Default sizes of the stores.
    localparam int DEF_MAX_ROWS     = 1024;
    localparam int DEF_MAX_COLS     = 1024;
    localparam int DEF_MAX_NONZEROS = 16384;

    // Field widths.
    localparam int CMD_W    = 2;
    localparam int COL_W    = 10;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int SWEEP_W  = 20;
    localparam int ROWS_W   = 11;
    localparam int COLS_W   = 11;
    localparam int PAT_W    = 7;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 24;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_VALUE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

    // Register indexes (word address bits).
    localparam logic [1:0] REG_NUM_ROWS   = 2'd0;
    localparam logic [1:0] REG_NUM_COLS   = 2'd1;
    localparam logic [1:0] REG_MAX_SWEEPS = 2'd2;
    localparam logic [1:0] REG_PATIENCE   = 2'd3;

    // Register reset values.
    localparam logic [ROWS_W-1:0]  RST_NUM_ROWS   = 11'd1024;
    localparam logic [COLS_W-1:0]  RST_NUM_COLS   = 11'd1024;
    localparam logic [SWEEP_W-1:0] RST_MAX_SWEEPS = 20'd50;
    localparam logic [PAT_W-1:0]   RST_PATIENCE   = 7'd8;

    localparam logic [PAT_W-1:0]   RUN_MAX       = 7'd127;
    localparam logic [SWEEP_W-1:0] REPORT_OFFSET = 20'd7;
    localparam logic [6:0]         DIV_STEPS     = 7'd88;

    function automatic logic [63:0] mul_s32(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] ea;
        logic signed [63:0] eb;
        ea = $signed({{32{a[31]}}, a});
        eb = $signed({{32{b[31]}}, b});
        return ea * eb;
    endfunction

    function automatic logic [63:0] sat_add_s64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return s;
    endfunction

    function automatic logic [63:0] sat_sub_s64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
            return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return s;
    endfunction

    function automatic logic [63:0] sat_add_u64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [31:0] sat32_s41(input logic [40:0] v);
        if (v[40:31] == 10'h000 || v[40:31] == 10'h3FF)
            return v[31:0];
        return v[40] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

endpackage

/* rtl/core/tks_ram.sv */
module tks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/twin_kaczmarz_sparse_solver.sv */
// Channel     | Signals                                   | Transaction
// ------------+-------------------------------------------+--------------------------------
// command in  | start, busy, cmd, col_index, value        | start high while busy is low
// result out  | done, status, sweeps_done, x_value        | done high for one cycle
// config      | psel, penable, pwrite, paddr, pwdata,     | access phase with pready high
//             | prdata, pready                            |
//
// Loads (cmd 0) keep busy low; closing a row and a read pass through their own states.
// A solve first clears both estimates, then each sweep runs a projection for every
// row, dominated by the 88-step bit-serial divider, and then the difference pass.
// After reset the block clears both estimate memories with busy high.
// The receiver cannot stall: a result is shown for exactly one cycle.
module twin_kaczmarz_sparse_solver #(
    parameter int MAX_ROWS     = tks_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS     = tks_pkg::DEF_MAX_COLS,
    parameter int MAX_NONZEROS = tks_pkg::DEF_MAX_NONZEROS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tks_pkg::CMD_W-1:0]      cmd,
    input  logic [tks_pkg::COL_W-1:0]      col_index,
    input  logic signed [tks_pkg::VAL_W-1:0] value,
    output logic                           done,
    output logic [tks_pkg::STATUS_W-1:0]   status,
    output logic [tks_pkg::SWEEP_W-1:0]    sweeps_done,
    output logic signed [tks_pkg::VAL_W-1:0] x_value,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tks_pkg::ADDR_W-1:0]     paddr,
    input  logic [tks_pkg::DATA_W-1:0]     pwdata,
    output logic [tks_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    localparam int NZ_AW  = $clog2(MAX_NONZEROS);
    localparam int PW     = NZ_AW + 1;
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int RW1    = RW + 1;
    localparam int CW     = $clog2(MAX_COLS);
    localparam int CW1    = CW + 1;
    localparam int NZ_DW  = tks_pkg::COL_W + tks_pkg::VAL_W;
    localparam int ROW_DW = 2 * PW + 96;

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_CLOSE    = 4'd2;
    localparam logic [3:0] S_READ     = 4'd3;
    localparam logic [3:0] S_CLEAR    = 4'd4;
    localparam logic [3:0] S_TOP      = 4'd5;
    localparam logic [3:0] S_ROW_RD   = 4'd6;
    localparam logic [3:0] S_ROW_WAIT = 4'd7;
    localparam logic [3:0] S_DOT      = 4'd8;
    localparam logic [3:0] S_RESID    = 4'd9;
    localparam logic [3:0] S_MAG      = 4'd10;
    localparam logic [3:0] S_DIV      = 4'd11;
    localparam logic [3:0] S_SCALE    = 4'd12;
    localparam logic [3:0] S_UPD      = 4'd13;
    localparam logic [3:0] S_DIFF     = 4'd14;
    localparam logic [3:0] S_RULE     = 4'd15;

    logic [3:0] state_reg, state_next;

    logic [tks_pkg::ROWS_W-1:0]  num_rows_reg, num_rows_next;
    logic [tks_pkg::COLS_W-1:0]  num_cols_reg, num_cols_next;
    logic [tks_pkg::SWEEP_W-1:0] max_sweeps_reg, max_sweeps_next;
    logic [tks_pkg::PAT_W-1:0]   patience_reg, patience_next;

    logic [PW-1:0]  lp_reg, lp_next;
    logic [PW-1:0]  row_start_reg, row_start_next;
    logic [RW1-1:0] rows_reg, rows_next;
    logic [63:0]    norm_acc_reg, norm_acc_next;
    logic           ld_v1_reg, ld_v1_next;
    logic [31:0]    ld_val_reg, ld_val_next;
    logic           ld_v2_reg, ld_v2_next;
    logic [63:0]    ld_sq_reg, ld_sq_next;
    logic           zero_seen_reg, zero_seen_next;
    logic [RW-1:0]  zero_row_reg, zero_row_next;
    logic [31:0]    close_rhs_reg, close_rhs_next;

    logic [CW1-1:0] clr_reg, clr_next;
    logic [RW1-1:0] cnt_i_reg, cnt_i_next;
    logic           side_reg, side_next;
    logic [PW-1:0]  k_reg, k_next;
    logic [PW-1:0]  k_end_reg, k_end_next;
    logic [31:0]    rhs_row_reg, rhs_row_next;
    logic [63:0]    norm_row_reg, norm_row_next;
    logic [63:0]    dot_reg, dot_next;
    logic [63:0]    resid_reg, resid_next;
    logic           neg_reg, neg_next;
    logic [87:0]    dvd_reg, dvd_next;
    logic [63:0]    rem_reg, rem_next;
    logic [32:0]    quo_reg, quo_next;
    logic           ovf_reg, ovf_next;
    logic [6:0]     dcnt_reg, dcnt_next;
    logic [31:0]    scale_reg, scale_next;

    logic           p1_valid_reg, p1_valid_next;
    logic           p2_valid_reg, p2_valid_next;
    logic [CW-1:0]  p2_col_reg, p2_col_next;
    logic [31:0]    p2_val_reg, p2_val_next;
    logic [63:0]    p2_prod_reg, p2_prod_next;
    logic           p2_fwd_reg, p2_fwd_next;
    logic [31:0]    p2_fwdd_reg, p2_fwdd_next;
    logic           p3_valid_reg, p3_valid_next;
    logic [63:0]    p3_prod_reg, p3_prod_next;

    logic [CW1-1:0] j_reg, j_next;
    logic           q1_reg, q1_next;
    logic           q2_reg, q2_next;
    logic [31:0]    mag_reg, mag_next;
    logic           q3_reg, q3_next;
    logic [63:0]    sq_reg, sq_next;
    logic [63:0]    diff_reg, diff_next;
    logic [63:0]    ref_diff_reg, ref_diff_next;
    logic           ref_valid_reg, ref_valid_next;
    logic [tks_pkg::PAT_W-1:0]   run_reg, run_next;
    logic [tks_pkg::SWEEP_W-1:0] sweep_reg, sweep_next;

    logic           rd_ok_reg, rd_ok_next;
    logic           done_reg, done_next;
    logic [tks_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [tks_pkg::SWEEP_W-1:0]  sweeps_out_reg, sweeps_out_next;
    logic [31:0]    xval_reg, xval_next;

    // Memory ports.
    logic              nz_we;
    logic [NZ_AW-1:0]  nz_waddr, nz_raddr;
    logic [NZ_DW-1:0]  nz_wdata, nz_rdata;
    logic              row_we;
    logic [RW-1:0]     row_waddr, row_raddr;
    logic [ROW_DW-1:0] row_wdata, row_rdata;
    logic              xf_we, xb_we;
    logic [CW-1:0]     x_waddr, x_raddr;
    logic [31:0]       x_wdata, xf_rdata, xb_rdata;

    tks_ram #(.WIDTH(NZ_DW), .DEPTH(MAX_NONZEROS)) u_nz_ram (
        .clk(clk), .we(nz_we), .waddr(nz_waddr), .wdata(nz_wdata),
        .raddr(nz_raddr), .rdata(nz_rdata)
    );

    tks_ram #(.WIDTH(ROW_DW), .DEPTH(MAX_ROWS)) u_row_ram (
        .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
        .raddr(row_raddr), .rdata(row_rdata)
    );

    tks_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_xf_ram (
        .clk(clk), .we(xf_we), .waddr(x_waddr), .wdata(x_wdata),
        .raddr(x_raddr), .rdata(xf_rdata)
    );

    tks_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_xb_ram (
        .clk(clk), .we(xb_we), .waddr(x_waddr), .wdata(x_wdata),
        .raddr(x_raddr), .rdata(xb_rdata)
    );

    // Derived values.
    logic        accept;
    logic [31:0] m_full, n_full, row_idx32, cmd_col32, p1_col32;
    logic        p1_hit;
    logic [CW-1:0] p1_xaddr;
    logic [31:0] x_rd, x_old, x_new;
    logic [63:0] upd_tmp;
    logic [40:0] upd_sum;
    logic [64:0] rem_sh;
    logic        div_ge;
    logic [32:0] div_limit, qsat, qneg;
    logic [32:0] d33, dneg, avg33;
    logic        rule_better;
    logic [tks_pkg::PAT_W-1:0] run_inc;
    logic        start_err;
    logic [63:0] resid_mag;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign pready    = 1'b1;
    assign done      = done_reg;
    assign status    = status_reg;
    assign sweeps_done = sweeps_out_reg;
    assign x_value   = xval_reg;

    assign m_full = (32'(num_rows_reg) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(num_rows_reg);
    assign n_full = (32'(num_cols_reg) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(num_cols_reg);
    assign row_idx32 = side_reg ? (m_full - 32'd1 - 32'(cnt_i_reg)) : 32'(cnt_i_reg);
    assign cmd_col32 = 32'(col_index);
    assign p1_col32  = 32'(nz_rdata[NZ_DW-1:tks_pkg::VAL_W]);
    assign p1_hit    = p1_valid_reg && (p1_col32 < n_full);
    assign p1_xaddr  = p1_col32[CW-1:0];

    // Update path: the same column may come back one entry later, so the
    // value being written is forwarded in place of the stale memory read.
    assign x_rd    = side_reg ? xb_rdata : xf_rdata;
    assign x_old   = p2_fwd_reg ? p2_fwdd_reg : x_rd;
    assign upd_tmp = p2_prod_reg + 64'h0000_0000_0080_0000;
    assign upd_sum = {{9{x_old[31]}}, x_old} + {upd_tmp[63], upd_tmp[63:24]};
    assign x_new   = tks_pkg::sat32_s41(upd_sum);

    assign rem_sh    = {rem_reg, dvd_reg[87]};
    assign div_ge    = rem_sh >= {1'b0, norm_row_reg};
    assign div_limit = neg_reg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    assign qsat      = (ovf_reg || quo_reg > div_limit) ? div_limit : quo_reg;
    assign qneg      = ~qsat + 33'd1;
    assign resid_mag = resid_reg[63] ? (~resid_reg + 64'd1) : resid_reg;

    assign d33   = {xb_rdata[31], xb_rdata} - {xf_rdata[31], xf_rdata};
    assign dneg  = ~d33 + 33'd1;
    assign avg33 = {xf_rdata[31], xf_rdata} + {xb_rdata[31], xb_rdata};

    assign rule_better = !ref_valid_reg || (diff_reg < ref_diff_reg);
    assign run_inc     = (run_reg < tks_pkg::RUN_MAX) ? run_reg + 7'd1 : run_reg;
    assign start_err   = (m_full > 32'(rows_reg))
                      || (zero_seen_reg && (32'(zero_row_reg) < m_full));

    always_comb
    begin
        case (paddr[3:2])
            tks_pkg::REG_NUM_ROWS:   prdata = 32'(num_rows_reg);
            tks_pkg::REG_NUM_COLS:   prdata = 32'(num_cols_reg);
            tks_pkg::REG_MAX_SWEEPS: prdata = 32'(max_sweeps_reg);
            tks_pkg::REG_PATIENCE:   prdata = 32'(patience_reg);
            default:                 prdata = '0;
        endcase
    end

    // Memory addressing.
    always_comb
    begin
        nz_we     = accept && (cmd == tks_pkg::CMD_LOAD) && (32'(lp_reg) < 32'(MAX_NONZEROS));
        nz_waddr  = lp_reg[NZ_AW-1:0];
        nz_wdata  = {col_index, value};
        nz_raddr  = k_reg[NZ_AW-1:0];

        row_we    = (state_reg == S_CLOSE) && !ld_v1_reg && !ld_v2_reg;
        row_waddr = rows_reg[RW-1:0];
        row_wdata = {row_start_reg, lp_reg, close_rhs_reg, norm_acc_reg};
        row_raddr = row_idx32[RW-1:0];

        case (state_reg)
            S_DIFF:        x_raddr = j_reg[CW-1:0];
            S_DOT, S_UPD:  x_raddr = p1_xaddr;
            default:       x_raddr = cmd_col32[CW-1:0];
        endcase

        if (state_reg == S_INIT || state_reg == S_CLEAR)
        begin
            xf_we   = 1'b1;
            xb_we   = 1'b1;
            x_waddr = clr_reg[CW-1:0];
            x_wdata = '0;
        end
        else
        begin
            xf_we   = (state_reg == S_UPD) && p2_valid_reg && !side_reg;
            xb_we   = (state_reg == S_UPD) && p2_valid_reg && side_reg;
            x_waddr = p2_col_reg;
            x_wdata = x_new;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        num_rows_next   = num_rows_reg;
        num_cols_next   = num_cols_reg;
        max_sweeps_next = max_sweeps_reg;
        patience_next   = patience_reg;
        lp_next         = lp_reg;
        row_start_next  = row_start_reg;
        rows_next       = rows_reg;
        norm_acc_next   = norm_acc_reg;
        ld_v1_next      = 1'b0;
        ld_val_next     = ld_val_reg;
        ld_v2_next      = ld_v1_reg;
        ld_sq_next      = tks_pkg::mul_s32(ld_val_reg, ld_val_reg);
        zero_seen_next  = zero_seen_reg;
        zero_row_next   = zero_row_reg;
        close_rhs_next  = close_rhs_reg;
        clr_next        = clr_reg;
        cnt_i_next      = cnt_i_reg;
        side_next       = side_reg;
        k_next          = k_reg;
        k_end_next      = k_end_reg;
        rhs_row_next    = rhs_row_reg;
        norm_row_next   = norm_row_reg;
        dot_next        = dot_reg;
        resid_next      = resid_reg;
        neg_next        = neg_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        ovf_next        = ovf_reg;
        dcnt_next       = dcnt_reg;
        scale_next      = scale_reg;
        p1_valid_next   = 1'b0;
        p2_valid_next   = 1'b0;
        p2_col_next     = p1_xaddr;
        p2_val_next     = nz_rdata[tks_pkg::VAL_W-1:0];
        p2_prod_next    = tks_pkg::mul_s32(scale_reg, nz_rdata[tks_pkg::VAL_W-1:0]);
        p2_fwd_next     = 1'b0;
        p2_fwdd_next    = x_new;
        p3_valid_next   = 1'b0;
        p3_prod_next    = tks_pkg::mul_s32(p2_val_reg, x_rd);
        j_next          = j_reg;
        q1_next         = 1'b0;
        q2_next         = q1_reg;
        mag_next        = d33[32] ? dneg[31:0] : d33[31:0];
        q3_next         = q2_reg;
        sq_next         = {32'd0, mag_reg} * {32'd0, mag_reg};
        diff_next       = diff_reg;
        ref_diff_next   = ref_diff_reg;
        ref_valid_next  = ref_valid_reg;
        run_next        = run_reg;
        sweep_next      = sweep_reg;
        rd_ok_next      = rd_ok_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        sweeps_out_next = sweeps_out_reg;
        xval_next       = xval_reg;

        if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                tks_pkg::REG_NUM_ROWS:   num_rows_next   = pwdata[tks_pkg::ROWS_W-1:0];
                tks_pkg::REG_NUM_COLS:   num_cols_next   = pwdata[tks_pkg::COLS_W-1:0];
                tks_pkg::REG_MAX_SWEEPS: max_sweeps_next = pwdata[tks_pkg::SWEEP_W-1:0];
                tks_pkg::REG_PATIENCE:   patience_next   = pwdata[tks_pkg::PAT_W-1:0];
                default:                 num_rows_next   = num_rows_reg;
            endcase
        end

        // Row norm accumulation trails the loads through the ld_v1 and ld_v2 stages.
        if (ld_v2_reg)
        begin
            norm_acc_next = tks_pkg::sat_add_u64(norm_acc_reg, ld_sq_reg);
        end

        if (q3_reg)
        begin
            diff_next = tks_pkg::sat_add_u64(diff_reg, sq_reg);
        end

        if (p3_valid_reg)
        begin
            dot_next = tks_pkg::sat_add_s64(dot_reg, p3_prod_reg);
        end

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                clr_next = clr_reg + CW1'(1);
                if (32'(clr_reg) == 32'(MAX_COLS) - 32'd1)
                begin
                    clr_next   = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_TOP;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        tks_pkg::CMD_LOAD:
                        begin
                            if (nz_we)
                            begin
                                lp_next     = lp_reg + PW'(1);
                                ld_v1_next  = 1'b1;
                                ld_val_next = value;
                            end
                        end
                        tks_pkg::CMD_CLOSE:
                        begin
                            if (32'(rows_reg) < 32'(MAX_ROWS))
                            begin
                                close_rhs_next = value;
                                state_next     = S_CLOSE;
                            end
                        end
                        tks_pkg::CMD_READ:
                        begin
                            rd_ok_next = cmd_col32 < 32'(MAX_COLS);
                            state_next = S_READ;
                        end
                        default:
                        begin
                            if (start_err)
                            begin
                                done_next       = 1'b1;
                                status_next     = tks_pkg::ST_ERROR;
                                sweeps_out_next = '0;
                                xval_next       = '0;
                            end
                            else
                            begin
                                ref_diff_next  = '0;
                                ref_valid_next = 1'b0;
                                run_next       = '0;
                                sweep_next     = '0;
                                clr_next       = '0;
                                state_next     = S_CLEAR;
                            end
                        end
                    endcase
                end
            end

            S_CLOSE:
            begin
                if (!ld_v1_reg && !ld_v2_reg)
                begin
                    if (norm_acc_reg == 64'd0 && !zero_seen_reg)
                    begin
                        zero_seen_next = 1'b1;
                        zero_row_next  = rows_reg[RW-1:0];
                    end
                    rows_next      = rows_reg + RW1'(1);
                    row_start_next = lp_reg;
                    norm_acc_next  = '0;
                    state_next     = S_IDLE;
                end
            end

            S_READ:
            begin
                done_next       = 1'b1;
                status_next     = tks_pkg::ST_VALUE;
                sweeps_out_next = '0;
                xval_next       = rd_ok_reg ? avg33[32:1] : 32'd0;
                state_next      = S_IDLE;
            end

            S_TOP:
            begin
                if (sweep_reg >= max_sweeps_reg)
                begin
                    done_next       = 1'b1;
                    status_next     = tks_pkg::ST_DONE;
                    sweeps_out_next = (sweep_reg > tks_pkg::REPORT_OFFSET)
                                    ? sweep_reg - tks_pkg::REPORT_OFFSET : '0;
                    xval_next       = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 20'd1;
                    cnt_i_next = '0;
                    side_next  = 1'b0;
                    diff_next  = '0;
                    j_next     = '0;
                    state_next = (m_full == 32'd0) ? S_DIFF : S_ROW_RD;
                end
            end

            S_ROW_RD:
            begin
                state_next = S_ROW_WAIT;
            end

            S_ROW_WAIT:
            begin
                k_next        = row_rdata[ROW_DW-1:PW+96];
                k_end_next    = row_rdata[PW+95:96];
                rhs_row_next  = row_rdata[95:64];
                norm_row_next = row_rdata[63:0];
                dot_next      = '0;
                state_next    = S_DOT;
            end

            S_DOT:
            begin
                if (k_reg < k_end_reg)
                begin
                    k_next        = k_reg + PW'(1);
                    p1_valid_next = 1'b1;
                end
                p2_valid_next = p1_hit;
                p3_valid_next = p2_valid_reg;
                if (!(k_reg < k_end_reg) && !p1_valid_reg && !p2_valid_reg && !p3_valid_reg)
                begin
                    state_next = S_RESID;
                end
            end

            S_RESID:
            begin
                resid_next = tks_pkg::sat_sub_s64({{8{rhs_row_reg[31]}}, rhs_row_reg, 24'd0},
                                                  dot_reg);
                state_next = S_MAG;
            end

            S_MAG:
            begin
                neg_next   = resid_reg[63];
                dvd_next   = {resid_mag, 24'd0};
                rem_next   = '0;
                quo_next   = '0;
                ovf_next   = 1'b0;
                dcnt_next  = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                rem_next  = div_ge ? 64'(rem_sh - {1'b0, norm_row_reg}) : rem_sh[63:0];
                dvd_next  = {dvd_reg[86:0], 1'b0};
                quo_next  = {quo_reg[31:0], div_ge};
                ovf_next  = ovf_reg | quo_reg[32];
                dcnt_next = dcnt_reg + 7'd1;
                if (dcnt_reg == tks_pkg::DIV_STEPS - 7'd1)
                begin
                    state_next = S_SCALE;
                end
            end

            S_SCALE:
            begin
                scale_next = neg_reg ? qneg[31:0] : qsat[31:0];
                k_next     = row_rdata[ROW_DW-1:PW+96];
                state_next = S_UPD;
            end

            S_UPD:
            begin
                if (k_reg < k_end_reg)
                begin
                    k_next        = k_reg + PW'(1);
                    p1_valid_next = 1'b1;
                end
                p2_valid_next = p1_hit;
                p2_fwd_next   = p1_hit && p2_valid_reg && (p2_col_reg == p1_xaddr);
                if (!(k_reg < k_end_reg) && !p1_valid_reg && !p2_valid_reg)
                begin
                    if (!side_reg)
                    begin
                        side_next  = 1'b1;
                        state_next = S_ROW_RD;
                    end
                    else
                    begin
                        side_next  = 1'b0;
                        cnt_i_next = cnt_i_reg + RW1'(1);
                        state_next = (32'(cnt_i_reg) + 32'd1 >= m_full) ? S_DIFF : S_ROW_RD;
                    end
                end
            end

            S_DIFF:
            begin
                if (32'(j_reg) < n_full)
                begin
                    j_next  = j_reg + CW1'(1);
                    q1_next = 1'b1;
                end
                if (!(32'(j_reg) < n_full) && !q1_reg && !q2_reg && !q3_reg)
                begin
                    state_next = S_RULE;
                end
            end

            S_RULE:
            begin
                if (rule_better)
                begin
                    ref_diff_next  = diff_reg;
                    ref_valid_next = 1'b1;
                    run_next       = 7'd1;
                    state_next     = S_TOP;
                end
                else
                begin
                    run_next = run_inc;
                    if (run_inc >= patience_reg)
                    begin
                        done_next       = 1'b1;
                        status_next     = tks_pkg::ST_DONE;
                        sweeps_out_next = (sweep_reg > tks_pkg::REPORT_OFFSET)
                                        ? sweep_reg - tks_pkg::REPORT_OFFSET : '0;
                        xval_next       = '0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_TOP;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            num_rows_reg   <= tks_pkg::RST_NUM_ROWS;
            num_cols_reg   <= tks_pkg::RST_NUM_COLS;
            max_sweeps_reg <= tks_pkg::RST_MAX_SWEEPS;
            patience_reg   <= tks_pkg::RST_PATIENCE;
            lp_reg         <= '0;
            row_start_reg  <= '0;
            rows_reg       <= '0;
            norm_acc_reg   <= '0;
            ld_v1_reg      <= 1'b0;
            ld_v2_reg      <= 1'b0;
            zero_seen_reg  <= 1'b0;
            zero_row_reg   <= '0;
            clr_reg        <= '0;
            cnt_i_reg      <= '0;
            side_reg       <= 1'b0;
            k_reg          <= '0;
            k_end_reg      <= '0;
            dcnt_reg       <= '0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            p2_fwd_reg     <= 1'b0;
            p3_valid_reg   <= 1'b0;
            j_reg          <= '0;
            q1_reg         <= 1'b0;
            q2_reg         <= 1'b0;
            q3_reg         <= 1'b0;
            diff_reg       <= '0;
            ref_diff_reg   <= '0;
            ref_valid_reg  <= 1'b0;
            run_reg        <= '0;
            sweep_reg      <= '0;
            rd_ok_reg      <= 1'b0;
            done_reg       <= 1'b0;
            status_reg     <= '0;
            sweeps_out_reg <= '0;
            xval_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            num_rows_reg   <= num_rows_next;
            num_cols_reg   <= num_cols_next;
            max_sweeps_reg <= max_sweeps_next;
            patience_reg   <= patience_next;
            lp_reg         <= lp_next;
            row_start_reg  <= row_start_next;
            rows_reg       <= rows_next;
            norm_acc_reg   <= norm_acc_next;
            ld_v1_reg      <= ld_v1_next;
            ld_v2_reg      <= ld_v2_next;
            zero_seen_reg  <= zero_seen_next;
            zero_row_reg   <= zero_row_next;
            clr_reg        <= clr_next;
            cnt_i_reg      <= cnt_i_next;
            side_reg       <= side_next;
            k_reg          <= k_next;
            k_end_reg      <= k_end_next;
            dcnt_reg       <= dcnt_next;
            p1_valid_reg   <= p1_valid_next;
            p2_valid_reg   <= p2_valid_next;
            p2_fwd_reg     <= p2_fwd_next;
            p3_valid_reg   <= p3_valid_next;
            j_reg          <= j_next;
            q1_reg         <= q1_next;
            q2_reg         <= q2_next;
            q3_reg         <= q3_next;
            diff_reg       <= diff_next;
            ref_diff_reg   <= ref_diff_next;
            ref_valid_reg  <= ref_valid_next;
            run_reg        <= run_next;
            sweep_reg      <= sweep_next;
            rd_ok_reg      <= rd_ok_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            sweeps_out_reg <= sweeps_out_next;
            xval_reg       <= xval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_val_reg    <= ld_val_next;
        ld_sq_reg     <= ld_sq_next;
        close_rhs_reg <= close_rhs_next;
        rhs_row_reg   <= rhs_row_next;
        norm_row_reg  <= norm_row_next;
        dot_reg       <= dot_next;
        resid_reg     <= resid_next;
        neg_reg       <= neg_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        ovf_reg       <= ovf_next;
        scale_reg     <= scale_next;
        p2_col_reg    <= p2_col_next;
        p2_val_reg    <= p2_val_next;
        p2_prod_reg   <= p2_prod_next;
        p2_fwdd_reg   <= p2_fwdd_next;
        p3_prod_reg   <= p3_prod_next;
        mag_reg       <= mag_next;
        sq_reg        <= sq_next;
    end

endmodule
